// ===== rtl/mtt_pkg.sv =====
package mtt_pkg;

  localparam int NUM_SLOTS_DEF = 16;
  localparam int TIME_BITS_DEF = 48;
  localparam int PERIOD_BITS   = 32;
  localparam int TAG_BITS      = 32;
  localparam int SLOT_BITS     = 4;
  localparam int DUE_BITS      = 48;

  typedef enum logic [1:0] {
    ACT_TICK    = 2'd0,
    ACT_ADD     = 2'd1,
    ACT_DEL_ONE = 2'd2,
    ACT_DEL_ALL = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_ZERO_DELAY  = 2'd1,
    ST_FULL        = 2'd2,
    ST_NOT_ACTIVE  = 2'd3
  } status_t;

  typedef struct packed {
    action_t                action;
    logic [PERIOD_BITS-1:0] delay_ms;
    logic                   periodic;
    logic [TAG_BITS-1:0]    tag;
    logic [SLOT_BITS-1:0]   slot;
  } cmd_t;

  typedef struct packed {
    logic                 kind;
    logic [SLOT_BITS-1:0] slot_out;
    logic [TAG_BITS-1:0]  fired_tag;
    status_t              status;
    logic [DUE_BITS-1:0]  next_due;
    logic                 last;
  } result_t;

endpackage

// ===== rtl/mtt_ram.sv =====
module mtt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/mtt_rem.sv =====
module mtt_rem #(
  parameter int DIVIDEND_BITS = mtt_pkg::TIME_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [DIVIDEND_BITS-1:0]       dividend,
  input  logic [mtt_pkg::PERIOD_BITS-1:0] divisor,
  output logic                           done,
  output logic [mtt_pkg::PERIOD_BITS-1:0] remainder
);

  import mtt_pkg::*;

  localparam int CNT_W = $clog2(DIVIDEND_BITS + 1);

  logic [DIVIDEND_BITS-1:0] shift;
  logic [PERIOD_BITS-1:0]   dvs;
  logic [CNT_W-1:0]         count;
  logic                     running;
  logic [PERIOD_BITS:0]     trial;
  logic [PERIOD_BITS:0]     diff;

  // Restoring division, one dividend bit per cycle. The partial remainder
  // stays below the divisor, so the trial value needs one extra bit only.
  assign trial = {remainder, shift[DIVIDEND_BITS-1]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        shift     <= dividend;
        dvs       <= divisor;
        remainder <= '0;
        count     <= CNT_W'(DIVIDEND_BITS);
        running   <= 1'b1;
      end else if (running) begin
        remainder <= diff[PERIOD_BITS] ? trial[PERIOD_BITS-1:0] : diff[PERIOD_BITS-1:0];
        shift     <= shift << 1;
        count     <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/multiplexed_timer_table_core.sv =====
// Channel    Ports                          Transfer
// command    start, busy, cmd               start high while busy low
// result     result_valid, result           one-cycle strobe, no back-pressure
//
// Every command runs a sweep over the wakeup memory, one slot per cycle, before its reply.
// Each fired slot then adds a read of its info, a new sweep and, when it is periodic, an
// update step; the remainder unit also runs when the slot fell at least one period behind.
// Reset clears the time and every active flag at once; the memories need no clearing
// pass. Results cannot be held off; busy stays high until the last one.
module multiplexed_timer_table_core #(
  parameter int NUM_SLOTS = mtt_pkg::NUM_SLOTS_DEF,
  parameter int TIME_BITS = mtt_pkg::TIME_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  mtt_pkg::cmd_t    cmd,
  output logic             busy,
  output logic             result_valid,
  output mtt_pkg::result_t result
);

  import mtt_pkg::*;

  localparam int SW     = $clog2(NUM_SLOTS);
  localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
  localparam int SUM_W  = TIME_BITS + 1;
  localparam int INFO_W = PERIOD_BITS + TAG_BITS;
  localparam logic [TIME_BITS-1:0] TMASK = {TIME_BITS{1'b1}};

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_FIRE_RD,
    S_FIRE_CALC,
    S_DIV,
    S_UPDATE
  } state_t;

  state_t                 state;
  logic [TIME_BITS-1:0]   cur_time;
  logic [NUM_SLOTS-1:0]   slot_active;
  logic                   is_tick;
  logic                   fired_any;
  logic                   stop;
  logic                   pend_kind;
  logic [SLOT_BITS-1:0]   pend_slot;
  logic [TAG_BITS-1:0]    pend_tag;
  status_t                pend_status;
  logic [CNT_W-1:0]       scan_cnt;
  logic                   cmp_vld;
  logic [SW-1:0]          cmp_idx;
  logic [TIME_BITS-1:0]   best;
  logic [SW-1:0]          best_idx;
  logic                   best_any;
  logic [TIME_BITS-1:0]   base;
  logic [PERIOD_BITS-1:0] fire_period;

  // Memory ports.
  logic                   wake_we;
  logic [SW-1:0]          wake_waddr;
  logic [TIME_BITS-1:0]   wake_wdata;
  logic [SW-1:0]          wake_raddr;
  logic [TIME_BITS-1:0]   wake_rdata;
  logic                   info_we;
  logic [INFO_W-1:0]      info_wdata;
  logic [INFO_W-1:0]      info_rdata;

  logic                   accept;
  logic                   free_found;
  logic [SW-1:0]          free_idx;
  logic                   add_ok;
  logic [SUM_W-1:0]       add_sum;
  logic [TIME_BITS-1:0]   add_wake;
  logic [31:0]            slot_wide;
  logic [SW-1:0]          del_idx;
  logic                   del_ok;
  logic                   expired;
  logic                   emit;
  logic                   finish;
  logic [63:0]            best_wide;
  logic [DUE_BITS-1:0]    due;
  logic [PERIOD_BITS-1:0] rd_period;
  logic [TAG_BITS-1:0]    rd_tag;
  logic [TIME_BITS-1:0]   lag;
  logic                   lag_short;
  logic                   rem_start;
  logic                   rem_done;
  logic [PERIOD_BITS-1:0] rem_value;
  logic [SUM_W-1:0]       upd_sum;
  logic [TIME_BITS-1:0]   upd_wake;
  logic                   scan_issue;
  result_t                result_next;

  assign accept = start && !busy;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!slot_active[i]) begin
        free_found = 1'b1;
        free_idx   = SW'(i);
      end
    end
  end

  assign add_ok   = (cmd.action == ACT_ADD) && (cmd.delay_ms != '0) && free_found;
  assign add_sum  = {1'b0, cur_time} + SUM_W'(cmd.delay_ms);
  assign add_wake = add_sum[TIME_BITS] ? TMASK : add_sum[TIME_BITS-1:0];

  assign slot_wide = 32'(cmd.slot);
  assign del_idx   = slot_wide[SW-1:0];
  assign del_ok    = (slot_wide < 32'(NUM_SLOTS)) && slot_active[del_idx];

  // The earliest active slot is also the earliest expired one when any slot
  // has expired, so one sweep yields both the next pick and next_due.
  assign expired   = best_any && (best <= cur_time);
  assign emit      = !is_tick || fired_any || !expired;
  assign finish    = !is_tick || stop || !expired;
  assign best_wide = 64'(best);
  assign due       = best_any ? best_wide[DUE_BITS-1:0] : {DUE_BITS{1'b1}};

  assign rd_period = info_rdata[INFO_W-1:TAG_BITS];
  assign rd_tag    = info_rdata[TAG_BITS-1:0];
  assign lag       = cur_time - best;
  assign lag_short = lag < TIME_BITS'(rd_period);
  assign rem_start = (state == S_FIRE_CALC) && (rd_period != '0) && !lag_short;

  // A periodic slot moves to now - ((now - wakeup) mod period) + period.
  assign upd_sum  = {1'b0, base} + SUM_W'(fire_period);
  assign upd_wake = upd_sum[TIME_BITS] ? TMASK : upd_sum[TIME_BITS-1:0];

  assign scan_issue = scan_cnt != CNT_W'(NUM_SLOTS);

  always_comb begin
    wake_we    = 1'b0;
    wake_waddr = best_idx;
    wake_wdata = upd_wake;
    info_we    = 1'b0;
    info_wdata = {(cmd.periodic ? cmd.delay_ms : '0), cmd.tag};
    wake_raddr = scan_issue ? scan_cnt[SW-1:0] : '0;
    if (state == S_IDLE && accept && add_ok) begin
      wake_we    = 1'b1;
      wake_waddr = free_idx;
      wake_wdata = add_wake;
      info_we    = 1'b1;
    end else if (state == S_UPDATE) begin
      wake_we = 1'b1;
    end
  end

  always_comb begin
    result_next.kind      = pend_kind;
    result_next.slot_out  = pend_slot;
    result_next.fired_tag = pend_tag;
    result_next.status    = pend_status;
    result_next.next_due  = due;
    result_next.last      = finish;
  end

  mtt_ram #(
    .WIDTH(TIME_BITS),
    .DEPTH(NUM_SLOTS)
  ) u_wake_ram (
    .clk  (clk),
    .we   (wake_we),
    .waddr(wake_waddr),
    .wdata(wake_wdata),
    .raddr(wake_raddr),
    .rdata(wake_rdata)
  );

  mtt_ram #(
    .WIDTH(INFO_W),
    .DEPTH(NUM_SLOTS)
  ) u_info_ram (
    .clk  (clk),
    .we   (info_we),
    .waddr(free_idx),
    .wdata(info_wdata),
    .raddr(best_idx),
    .rdata(info_rdata)
  );

  mtt_rem #(
    .DIVIDEND_BITS(TIME_BITS)
  ) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (lag),
    .divisor  (rd_period),
    .done     (rem_done),
    .remainder(rem_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      busy         <= 1'b0;
      result_valid <= 1'b0;
      cur_time     <= '0;
      slot_active  <= '0;
      is_tick      <= 1'b0;
      fired_any    <= 1'b0;
      stop         <= 1'b0;
      scan_cnt     <= '0;
      cmp_vld      <= 1'b0;
      best_any     <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            busy        <= 1'b1;
            state       <= S_SCAN;
            scan_cnt    <= '0;
            cmp_vld     <= 1'b0;
            best_any    <= 1'b0;
            fired_any   <= 1'b0;
            stop        <= 1'b0;
            is_tick     <= cmd.action == ACT_TICK;
            pend_kind   <= 1'b0;
            pend_slot   <= '0;
            pend_tag    <= '0;
            pend_status <= ST_OK;
            case (cmd.action)
              ACT_TICK: begin
                if (cur_time != TMASK) begin
                  cur_time <= cur_time + 1'b1;
                end
              end
              ACT_ADD: begin
                if (cmd.delay_ms == '0) begin
                  pend_status <= ST_ZERO_DELAY;
                end else if (!free_found) begin
                  pend_status <= ST_FULL;
                end else begin
                  slot_active[free_idx] <= 1'b1;
                  pend_slot             <= SLOT_BITS'(free_idx);
                end
              end
              ACT_DEL_ONE: begin
                if (del_ok) begin
                  slot_active[del_idx] <= 1'b0;
                  pend_slot            <= cmd.slot;
                end else begin
                  pend_status <= ST_NOT_ACTIVE;
                end
              end
              ACT_DEL_ALL: begin
                slot_active <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        S_SCAN: begin
          if (scan_issue) begin
            scan_cnt <= scan_cnt + 1'b1;
          end
          cmp_vld <= scan_issue;
          cmp_idx <= scan_cnt[SW-1:0];
          // Strict compare keeps the lowest slot on equal wakeups.
          if (cmp_vld && slot_active[cmp_idx] && (!best_any || wake_rdata < best)) begin
            best     <= wake_rdata;
            best_idx <= cmp_idx;
            best_any <= 1'b1;
          end
          if (cmp_vld && cmp_idx == SW'(NUM_SLOTS - 1)) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (emit) begin
            result_valid <= 1'b1;
            result       <= result_next;
          end
          if (finish) begin
            state <= S_IDLE;
            busy  <= 1'b0;
          end else begin
            state <= S_FIRE_RD;
          end
        end
        S_FIRE_RD: begin
          state <= S_FIRE_CALC;
        end
        S_FIRE_CALC: begin
          fired_any   <= 1'b1;
          pend_kind   <= 1'b1;
          pend_slot   <= SLOT_BITS'(best_idx);
          pend_tag    <= rd_tag;
          pend_status <= ST_OK;
          fire_period <= rd_period;
          if (rd_period == '0) begin
            slot_active[best_idx] <= 1'b0;
            stop     <= 1'b0;
            state    <= S_SCAN;
            scan_cnt <= '0;
            cmp_vld  <= 1'b0;
            best_any <= 1'b0;
          end else if (lag_short) begin
            base  <= best;
            state <= S_UPDATE;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (rem_done) begin
            base  <= cur_time - TIME_BITS'(rem_value);
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          // Still due only when both wakeup and time sit at the ceiling;
          // then this slot is the last one fired on this tick.
          stop     <= upd_wake <= cur_time;
          state    <= S_SCAN;
          scan_cnt <= '0;
          cmp_vld  <= 1'b0;
          best_any <= 1'b0;
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

  a_accept_quiet: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !result_valid)
    else $error("result strobe right after a command was taken");

  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.last) |-> !busy)
    else $error("final result while still busy");

  a_more_busy: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.last) |-> busy)
    else $error("non-final result while idle");

  a_time_mono: assert property (@(posedge clk) disable iff (rst)
    !rst |=> (cur_time >= $past(cur_time)))
    else $error("current time went backward");

endmodule

// ===== tb/multiplexed_timer_table_core_tb.sv =====
`timescale 1ns / 100ps

module multiplexed_timer_table_core_tb;
  import mtt_pkg::*;

  localparam int SLOTS         = NUM_SLOTS_DEF;
  localparam int RANDOM_ITEMS  = 500;
  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 4 * SLOTS;

  typedef logic [TIME_BITS_DEF-1:0] ms_t;

  localparam ms_t TIME_MAX = '1;
  localparam logic [DUE_BITS-1:0] NO_DUE = '1;

  typedef struct packed {
    cmd_t       c;
    logic [4:0] reps;
    logic       typed;
    result_t    want;
  } drill_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  cmd_t    cmd = '0;
  logic    busy;
  logic    result_valid;
  result_t result;

  // Timer table as the testbench sees it.
  ms_t         now_ms = '0;
  ms_t         wake [SLOTS];
  logic [31:0] period [SLOTS];
  logic [31:0] tags [SLOTS];
  bit          live [SLOTS];

  result_t step_results[$];
  result_t awaited_results[$];
  drill_t  drills[$];
  int      mismatches = 0;
  int      quiet_cycles = 0;

  multiplexed_timer_table_core dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .cmd          (cmd),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic ms_t sat_sum(input ms_t a, input ms_t b);
    logic [TIME_BITS_DEF:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_BITS_DEF] ? TIME_MAX : s[TIME_BITS_DEF-1:0];
  endfunction

  function automatic logic [DUE_BITS-1:0] soonest_wakeup();
    ms_t best;
    bit  any;
    best = TIME_MAX;
    any  = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (live[i] && (!any || wake[i] < best)) begin
        best = wake[i];
        any  = 1'b1;
      end
    end
    return any ? best[DUE_BITS-1:0] : NO_DUE;
  endfunction

  function automatic void log_outcome(input logic kind, input logic [3:0] sl,
                                      input logic [31:0] tag, input status_t st);
    result_t r;
    r.kind      = kind;
    r.slot_out  = sl;
    r.fired_tag = tag;
    r.status    = st;
    r.next_due  = soonest_wakeup();
    r.last      = 1'b0;
    step_results.push_back(r);
  endfunction

  // Applies one command to the table and leaves its results in step_results.
  task automatic apply_to_table(input cmd_t c);
    int      pick;
    int      fired;
    int      free_at;
    bit      done;
    ms_t     w;
    ms_t     p;
    result_t tail;
    step_results.delete();
    case (c.action)
      ACT_TICK: begin
        if (now_ms != TIME_MAX) now_ms = now_ms + 1'b1;
        fired = 0;
        done  = 1'b0;
        while (!done) begin
          pick = -1;
          for (int i = 0; i < SLOTS; i++) begin
            if (live[i] && wake[i] <= now_ms && (pick < 0 || wake[i] < wake[pick]))
              pick = i;
          end
          if (pick < 0 || fired >= SLOTS) begin
            done = 1'b1;
          end else begin
            if (period[pick] != 0) begin
              p = ms_t'(period[pick]);
              w = wake[pick];
              w = w + ((now_ms - w) / p) * p;
              wake[pick] = sat_sum(w, p);
            end else begin
              live[pick] = 1'b0;
            end
            log_outcome(1'b1, pick[3:0], tags[pick], ST_OK);
            fired++;
            // A slot pinned at the end of time fires only once per tick.
            if (live[pick] && wake[pick] <= now_ms) done = 1'b1;
          end
        end
        if (fired == 0) log_outcome(1'b0, 4'd0, 32'd0, ST_OK);
      end
      ACT_ADD: begin
        free_at = -1;
        for (int i = SLOTS - 1; i >= 0; i--) begin
          if (!live[i]) free_at = i;
        end
        if (c.delay_ms == 0) begin
          log_outcome(1'b0, 4'd0, 32'd0, ST_ZERO_DELAY);
        end else if (free_at < 0) begin
          log_outcome(1'b0, 4'd0, 32'd0, ST_FULL);
        end else begin
          live[free_at]   = 1'b1;
          wake[free_at]   = sat_sum(now_ms, ms_t'(c.delay_ms));
          period[free_at] = c.periodic ? c.delay_ms : 32'd0;
          tags[free_at]   = c.tag;
          log_outcome(1'b0, free_at[3:0], 32'd0, ST_OK);
        end
      end
      ACT_DEL_ONE: begin
        if (c.slot < SLOTS && live[c.slot]) begin
          live[c.slot] = 1'b0;
          log_outcome(1'b0, c.slot, 32'd0, ST_OK);
        end else begin
          log_outcome(1'b0, 4'd0, 32'd0, ST_NOT_ACTIVE);
        end
      end
      default: begin
        for (int i = 0; i < SLOTS; i++) live[i] = 1'b0;
        log_outcome(1'b0, 4'd0, 32'd0, ST_OK);
      end
    endcase
    tail = step_results[step_results.size() - 1];
    tail.last = 1'b1;
    step_results[step_results.size() - 1] = tail;
  endtask

  task automatic drill(input action_t a, input logic [31:0] delay, input logic per,
                       input logic [31:0] tag, input logic [3:0] sl, input int reps,
                       input logic typed, input logic [3:0] want_slot,
                       input status_t want_status, input logic [DUE_BITS-1:0] want_due);
    drill_t d;
    d.c.action         = a;
    d.c.delay_ms       = delay;
    d.c.periodic       = per;
    d.c.tag            = tag;
    d.c.slot           = sl;
    d.reps             = 5'(reps);
    d.typed            = typed;
    d.want.kind        = 1'b0;
    d.want.slot_out    = want_slot;
    d.want.fired_tag   = 32'd0;
    d.want.status      = want_status;
    d.want.next_due    = want_due;
    d.want.last        = 1'b1;
    drills.push_back(d);
  endtask

  function automatic cmd_t random_cmd();
    cmd_t        c;
    int unsigned pick;
    c.delay_ms = $urandom;
    c.periodic = 1'($urandom_range(0, 1));
    c.tag      = $urandom;
    c.slot     = 4'($urandom_range(0, 15));
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      c.action = ACT_TICK;
    end else if (pick < 80) begin
      c.action = ACT_ADD;
      // Mostly short delays so that timers actually fire.
      pick = $urandom_range(0, 9);
      if (pick == 0) c.delay_ms = '0;
      else if (pick > 1) c.delay_ms = $urandom_range(1, 8);
    end else if (pick < 97) begin
      c.action = ACT_DEL_ONE;
    end else begin
      c.action = ACT_DEL_ALL;
    end
    return c;
  endfunction

  task automatic issue(input cmd_t c, input logic typed, input result_t want,
                       input int unsigned gap);
    @(negedge clk);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    cmd   <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    apply_to_table(c);
    if (typed) begin
      awaited_results.push_back(want);
    end else begin
      foreach (step_results[k]) awaited_results.push_back(step_results[k]);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid) begin
      if (awaited_results.size() == 0) begin
        $error("result with no transaction outstanding: %h", result);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        if (result.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, result.kind);
          mismatches++;
        end
        if (result.slot_out !== want.slot_out) begin
          $error("slot_out: expected %0d, got %0d", want.slot_out, result.slot_out);
          mismatches++;
        end
        if (result.fired_tag !== want.fired_tag) begin
          $error("fired_tag: expected %h, got %h", want.fired_tag, result.fired_tag);
          mismatches++;
        end
        if (result.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, result.status);
          mismatches++;
        end
        if (result.next_due !== want.next_due) begin
          $error("next_due: expected %h, got %h", want.next_due, result.next_due);
          mismatches++;
        end
        if (result.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, result.last);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("multiplexed_timer_table_core test failed");
      $finish;
    end
  end

  initial begin
    drill_t  d;
    result_t none;
    bit      gaps_on;
    none = '0;

    // Time is 1 after the first tick; the comments track it.
    drill(ACT_TICK,    32'd0,          1'b0, 32'd0,          4'd0,  1,  1'b1, 4'd0,
          ST_OK,         NO_DUE);
    drill(ACT_DEL_ONE, 32'd0,          1'b0, 32'd0,          4'd0,  1,  1'b1, 4'd0,
          ST_NOT_ACTIVE, NO_DUE);
    drill(ACT_ADD,     32'd0,          1'b1, 32'hFFFF_FFFF,  4'hF,  1,  1'b1, 4'd0,
          ST_ZERO_DELAY, NO_DUE);
    drill(ACT_ADD,     32'hFFFF_FFFF,  1'b1, 32'hFFFF_FFFF,  4'hF,  1,  1'b1, 4'd0,
          ST_OK,         48'h1_0000_0000);
    drill(ACT_ADD,     32'd1,          1'b0, 32'hA5A5_A5A5,  4'd0,  1,  1'b1, 4'd1,
          ST_OK,         48'd2);
    drill(ACT_ADD,     32'd2,          1'b1, 32'h5A5A_5A5A,  4'd0,  1,  1'b0, 4'd0,
          ST_OK,         NO_DUE);
    drill(ACT_TICK,    32'd0,          1'b0, 32'd0,          4'd0,  4,  1'b0, 4'd0,
          ST_OK,         NO_DUE);
    drill(ACT_ADD,     32'd2,          1'b0, 32'd1,          4'd0,  1,  1'b0, 4'd0,
          ST_OK,         NO_DUE);
    drill(ACT_ADD,     32'd2,          1'b1, 32'd2,          4'd0,  1,  1'b0, 4'd0,
          ST_OK,         NO_DUE);
    // At time 7 slots 1, 2 and 3 are due together and must fire in slot order.
    drill(ACT_TICK,    32'd0,          1'b0, 32'd0,          4'd0,  2,  1'b0, 4'd0,
          ST_OK,         NO_DUE);
    drill(ACT_DEL_ONE, 32'd0,          1'b0, 32'd0,          4'd2,  1,  1'b0, 4'd2,
          ST_OK,         48'd9);
    drill(ACT_DEL_ONE, 32'd0,          1'b0, 32'd0,          4'hF,  1,  1'b1, 4'd0,
          ST_NOT_ACTIVE, 48'd9);
    drill(ACT_DEL_ALL, 32'd0,          1'b0, 32'd0,          4'd0,  1,  1'b1, 4'd0,
          ST_OK,         NO_DUE);
    drill(ACT_ADD,     32'd1000,       1'b0, 32'hDEAD_0001,  4'd0,  16, 1'b0, 4'd0,
          ST_OK,         NO_DUE);
    drill(ACT_ADD,     32'd5,          1'b0, 32'd0,          4'd0,  1,  1'b1, 4'd0,
          ST_FULL,       48'd1007);
    drill(ACT_DEL_ALL, 32'd0,          1'b0, 32'd0,          4'd0,  1,  1'b1, 4'd0,
          ST_OK,         NO_DUE);
    drill(ACT_ADD,     32'd1,          1'b1, 32'h0BAD_F00D,  4'd0,  16, 1'b0, 4'd0,
          ST_OK,         NO_DUE);
    // Every slot expires on the same tick.
    drill(ACT_TICK,    32'd0,          1'b0, 32'd0,          4'd0,  1,  1'b0, 4'd0,
          ST_OK,         NO_DUE);
    drill(ACT_DEL_ALL, 32'd0,          1'b0, 32'd0,          4'd0,  1,  1'b1, 4'd0,
          ST_OK,         NO_DUE);

    repeat (9) @(negedge clk);
    rst <= 1'b0;

    gaps_on = 1'b1;
    foreach (drills[r]) begin
      d = drills[r];
      for (int k = 0; k < d.reps; k++)
        issue(d.c, d.typed, d.want, gaps_on ? $urandom_range(0, 15) : 0);
    end
    drain();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) gaps_on = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 49) == 0) drain();
      issue(random_cmd(), 1'b0, none, gaps_on ? $urandom_range(0, 15) : 0);
    end
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("multiplexed_timer_table_core test passed");
    end else begin
      $display("multiplexed_timer_table_core test failed");
    end
    $finish;
  end

endmodule
